// File: design/lcgpd_pkg.sv
// Shared types and constants for the LCG with period detection.
`default_nettype none
package lcgpd_pkg;

  localparam int unsigned MUL_BITS = 32;
  localparam int unsigned MOD_BITS = 33;
  localparam int unsigned CNT_BITS = 33;
  localparam int unsigned OUT_BITS = 32;

  localparam logic [MUL_BITS-1:0] RESET_MULTIPLIER = 32'd214013;
  localparam logic [MUL_BITS-1:0] RESET_INCREMENT  = 32'd1;
  localparam logic [MOD_BITS-1:0] RESET_MODULUS    = 33'h1_0000_0000;
  localparam logic [OUT_BITS-1:0] RESET_SEED       = 32'd189231;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_MULTIPLIER = 2'd0;
  localparam logic [1:0] REG_INCREMENT  = 2'd1;
  localparam logic [1:0] REG_MODULUS    = 2'd2;

  // Operation codes of an input word
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic [MUL_BITS-1:0] multiplier;
    logic [MUL_BITS-1:0] increment;
    logic [MOD_BITS-1:0] modulus;
  } lcgpd_cfg_t;

  // Sequencer of the multiply / reduce unit
  typedef enum logic [2:0] {
    MM_IDLE,
    MM_MUL,
    MM_ADD,
    MM_DIV,
    MM_DONE
  } mm_state_e;

  // Word control of the top level
  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_RUN,
    CTL_PUSH
  } ctl_state_e;

endpackage
`default_nettype wire

// File: design/lcg_with_period_detect_core.sv
// Top level of the linear congruential generator with period detection.
`default_nettype none
// Each input word either loads a seed (operation 0) or advances the generator
// X = (multiplier*X + increment) mod modulus by one step (operation 1), and
// gives one output word: the new value, the steps since the reference value
// was last seen, and a flag set when a step lands on that reference. A seed
// load bypasses the multiply / reduce unit. A step goes through the
// bit-serial multiply / reduce unit: shift-add multiply, an add of the
// increment, then restoring remainder (skipped when the modulus is zero).
// No new input word is taken until the current one has been pushed to the
// output register; a finished word then waits there while the next input
// word is taken. Write configuration only while the block is idle.
module lcg_with_period_detect_core
  import lcgpd_pkg::*;
#(
  parameter int unsigned STATE_BITS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [MOD_BITS-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                operation_i,
  input  wire logic [OUT_BITS-1:0] seed_value_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [OUT_BITS-1:0]      value_o,
  output logic [CNT_BITS-1:0]      step_count_o,
  output logic                     period_complete_o
);

  ctl_state_e            ctl_q, ctl_d;
  lcgpd_cfg_t            cfg_q;
  logic [STATE_BITS-1:0] cur_q, ref_q;
  logic [CNT_BITS-1:0]   steps_q;
  logic                  flag_q;
  logic                  out_valid_q;
  logic [OUT_BITS-1:0]   out_value_q;
  logic [CNT_BITS-1:0]   out_count_q;
  logic                  out_flag_q;

  logic                  in_accept;
  logic                  start_step;
  logic                  push;
  logic                  mm_done;
  logic [STATE_BITS-1:0] mm_next;
  logic [CNT_BITS-1:0]   steps_inc;

  assign in_accept  = in_valid_i && in_ready_o;
  assign start_step = in_accept && (operation_i == OP_STEP);
  assign steps_inc  = (steps_q == '1) ? steps_q : steps_q + 1'b1;

  lcgpd_mulmod #(
    .STATE_BITS(STATE_BITS)
  ) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_step),
    .x_i    (cur_q),
    .cfg_i  (cfg_q),
    .done_o (mm_done),
    .next_o (mm_next)
  );

  // Next state
  always_comb begin
    ctl_d = ctl_q;
    case (ctl_q)
      CTL_IDLE: if (in_accept) ctl_d = (operation_i == OP_STEP) ? CTL_RUN : CTL_PUSH;
      CTL_RUN:  if (mm_done) ctl_d = CTL_PUSH;
      CTL_PUSH: if (!out_valid_q || out_ready_i) ctl_d = CTL_IDLE;
      default:  ctl_d = CTL_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o        = (ctl_q == CTL_IDLE);
    push              = (ctl_q == CTL_PUSH) && (!out_valid_q || out_ready_i);
    out_valid_o       = out_valid_q;
    value_o           = out_value_q;
    step_count_o      = out_count_q;
    period_complete_o = out_flag_q;
  end

  // Write configuration registers, drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.multiplier <= RESET_MULTIPLIER;
      cfg_q.increment  <= RESET_INCREMENT;
      cfg_q.modulus    <= RESET_MODULUS;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MULTIPLIER: cfg_q.multiplier <= cfg_wdata_i[MUL_BITS-1:0];
        REG_INCREMENT:  cfg_q.increment  <= cfg_wdata_i[MUL_BITS-1:0];
        REG_MODULUS:    cfg_q.modulus    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance generator state: load a seed or take the unit's result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q   <= CTL_IDLE;
      cur_q   <= RESET_SEED[STATE_BITS-1:0];
      ref_q   <= RESET_SEED[STATE_BITS-1:0];
      steps_q <= '0;
      flag_q  <= 1'b0;
    end else begin
      ctl_q <= ctl_d;
      if (in_accept && (operation_i == OP_LOAD)) begin
        cur_q   <= seed_value_i[STATE_BITS-1:0];
        ref_q   <= seed_value_i[STATE_BITS-1:0];
        steps_q <= '0;
        flag_q  <= 1'b0;
      end else if ((ctl_q == CTL_RUN) && mm_done) begin
        cur_q <= mm_next;
        if (mm_next == ref_q) begin
          steps_q <= '0;
          flag_q  <= 1'b1;
        end else begin
          steps_q <= steps_inc;
          flag_q  <= 1'b0;
        end
      end
    end
  end

  // Hold the output word until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_value_q <= OUT_BITS'(cur_q);
      out_count_q <= steps_q;
      out_flag_q  <= flag_q;
    end
  end

  // A result from the unit arrives only while a step is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_done |-> (ctl_q == CTL_RUN))
    else $error("multiply unit finished outside a step");

  // A seed load resets the period reference and the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (operation_i == OP_LOAD)) |=> (steps_q == '0) && (cur_q == ref_q))
    else $error("seed load left stale period state");

  // A completed period always restarts the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flag_q |-> (steps_q == '0) && (cur_q == ref_q))
    else $error("period flag without count restart");

  // An accepted step starts the unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_step |=> (ctl_q == CTL_RUN) && !in_ready_o)
    else $error("step word did not start the unit");

endmodule
`default_nettype wire

// File: design/lcgpd_mulmod.sv
// Bit-serial unit that forms (a*x + c) mod m one bit per cycle; a zero m leaves the sum unreduced.
`default_nettype none
module lcgpd_mulmod
  import lcgpd_pkg::*;
#(
  parameter int unsigned STATE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [STATE_BITS-1:0] x_i,
  input  wire lcgpd_cfg_t            cfg_i,
  output logic                       done_o,
  output logic [STATE_BITS-1:0]      next_o
);

  localparam int unsigned PW = MUL_BITS + STATE_BITS;
  localparam int unsigned CW = $clog2(PW + 1);

  mm_state_e           state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [PW-1:0]       acc_q, acc_d;
  logic [MOD_BITS-1:0] rem_q, rem_d;

  logic                mod_zero;
  logic [MUL_BITS:0]   part_sum;
  logic [PW-1:0]       acc_sum;
  logic [MOD_BITS:0]   rem_sh;
  logic [MOD_BITS:0]   rem_diff;
  logic [MOD_BITS:0]   mod_ext;

  assign mod_zero = (cfg_i.modulus == '0);
  assign mod_ext  = {1'b0, cfg_i.modulus};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      MM_IDLE: if (start_i) state_d = MM_MUL;
      MM_MUL:  if (cnt_q == '0) state_d = MM_ADD;
      MM_ADD:  state_d = mod_zero ? MM_DONE : MM_DIV;
      MM_DIV:  if (cnt_q == '0) state_d = MM_DONE;
      MM_DONE: state_d = MM_IDLE;
      default: state_d = MM_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done_o = (state_q == MM_DONE);
    next_o = rem_q[STATE_BITS-1:0];
  end

  // Datapath: shift-add multiply, add of the increment, then restoring remainder, one bit a cycle
  always_comb begin
    part_sum = {1'b0, acc_q[PW-1:STATE_BITS]}
             + (acc_q[0] ? {1'b0, cfg_i.multiplier} : '0);
    acc_sum  = acc_q + PW'(cfg_i.increment);
    rem_sh   = {rem_q, acc_q[PW-1]};
    rem_diff = rem_sh - mod_ext;
    acc_d    = acc_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    case (state_q)
      MM_IDLE: begin
        if (start_i) begin
          acc_d = PW'(x_i);
          cnt_d = CW'(STATE_BITS - 1);
        end
      end
      MM_MUL: begin
        acc_d = {part_sum, acc_q[STATE_BITS-1:1]};
        cnt_d = cnt_q - 1'b1;
      end
      MM_ADD: begin
        acc_d = acc_sum;
        cnt_d = CW'(PW - 1);
        rem_d = mod_zero ? MOD_BITS'(acc_sum[STATE_BITS-1:0]) : '0;
      end
      MM_DIV: begin
        acc_d = {acc_q[PW-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        rem_d = (rem_sh >= mod_ext) ? rem_diff[MOD_BITS-1:0] : rem_sh[MOD_BITS-1:0];
      end
      default: ;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MM_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Hold datapath
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

endmodule
`default_nettype wire

// File: dv/lcg_with_period_detect_core_tb.sv
// Self-checking testbench for the LCG core with period detection.
`timescale 1ns / 1ps
module lcg_with_period_detect_core_tb;
  import lcgpd_pkg::*;

  localparam int unsigned STATE_BITS = 32;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 110;
  localparam int unsigned SQUEEZE_AT = 300;
  localparam int unsigned SQUEEZE_CYCLES = 400;
  localparam int unsigned WORDS_PER_SETTING = 88;

  typedef struct packed {
    logic [OUT_BITS-1:0] value;
    logic [CNT_BITS-1:0] steps;
    logic                wrapped;
  } lcg_word_t;

  typedef enum logic {
    ROW_REG,
    ROW_WORD
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [1:0]          reg_idx;
    logic [MOD_BITS-1:0] wdata;
    logic                op;
    logic [OUT_BITS-1:0] seed;
    logic                known;
    lcg_word_t           want;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_index_i = REG_MULTIPLIER;
  logic [MOD_BITS-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                operation_i = OP_LOAD;
  logic [OUT_BITS-1:0] seed_value_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [OUT_BITS-1:0] value_o;
  logic [CNT_BITS-1:0] step_count_o;
  logic                period_complete_o;

  // Predicted generator state and register copy
  lcgpd_cfg_t          gen_cfg;
  logic [OUT_BITS-1:0] gen_value;
  logic [OUT_BITS-1:0] gen_anchor;
  logic [CNT_BITS-1:0] gen_steps;

  lcg_word_t   words_due[$];
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  bit          cfg_busy = 1'b0;

  lcg_with_period_detect_core #(
    .STATE_BITS(STATE_BITS)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .seed_value_i     (seed_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .value_o          (value_o),
    .step_count_o     (step_count_o),
    .period_complete_o(period_complete_o)
  );

  always #2 clk_i = ~clk_i;

  // Idle rates: sender light / receiver heavy, then swapped, then none
  function automatic int unsigned sender_gap_pct();
    if (words_sent < 240) return 10;
    if (words_sent < 480) return 48;
    return 0;
  endfunction

  function automatic int unsigned receiver_gap_pct();
    if (words_sent < 240) return 48;
    if (words_sent < 480) return 10;
    return 0;
  endfunction

  // Advance the predicted generator by one input word
  function automatic lcg_word_t next_lcg_word(input logic op, input logic [OUT_BITS-1:0] seed);
    logic [63:0] sum;
    lcg_word_t   w;
    w.wrapped = 1'b0;
    if (op == OP_LOAD) begin
      gen_value  = seed;
      gen_anchor = seed;
      gen_steps  = '0;
    end else begin
      sum = 64'(gen_cfg.multiplier) * 64'(gen_value) + 64'(gen_cfg.increment);
      // zero modulus leaves the sum unreduced
      if (gen_cfg.modulus != '0) sum = sum % 64'(gen_cfg.modulus);
      gen_value = sum[OUT_BITS-1:0];
      if (gen_steps != '1) gen_steps = gen_steps + 1'b1;
      if (gen_value == gen_anchor) begin
        w.wrapped = 1'b1;
        gen_steps = '0;
      end
    end
    w.value = gen_value;
    w.steps = gen_steps;
    return w;
  endfunction

  function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [MOD_BITS-1:0] data);
    plan_row_t r;
    r = '0;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.wdata   = data;
    return r;
  endfunction

  function automatic plan_row_t word_row(input logic op, input logic [OUT_BITS-1:0] seed);
    plan_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.op   = op;
    r.seed = seed;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic op, input logic [OUT_BITS-1:0] seed,
                                          input logic [OUT_BITS-1:0] value,
                                          input logic [CNT_BITS-1:0] steps,
                                          input logic wrapped);
    plan_row_t r;
    r = word_row(op, seed);
    r.known = 1'b1;
    r.want  = '{value: value, steps: steps, wrapped: wrapped};
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
  endtask

  // Drop valid and wait until every word has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [MOD_BITS-1:0] data);
    if (!cfg_busy) settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_MULTIPLIER: gen_cfg.multiplier = data[MUL_BITS-1:0];
      REG_INCREMENT:  gen_cfg.increment = data[MUL_BITS-1:0];
      REG_MODULUS:    gen_cfg.modulus = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_busy = 1'b1;
  endtask

  // Offer one word, hold it until accepted, then queue its prediction
  task automatic send_word(input logic op, input logic [OUT_BITS-1:0] seed,
                           input logic known, input lcg_word_t want);
    lcg_word_t w;
    if (cfg_busy) begin
      cfg_we_i <= 1'b0;
      cfg_busy = 1'b0;
    end
    while ($urandom_range(99) < sender_gap_pct()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    seed_value_i <= seed;
    do @(posedge clk_i); while (!in_ready_o);
    w = next_lcg_word(op, seed);
    words_due.push_back(known ? want : w);
    words_sent++;
  endtask

  task automatic send_random(input logic op, input logic [OUT_BITS-1:0] seed);
    send_word(op, seed, 1'b0, '0);
  endtask

  // Pick one register setting of the random part
  task automatic apply_setting(input int unsigned sel);
    logic [MOD_BITS-1:0] m;
    case (sel)
      0: begin
        write_reg(REG_MULTIPLIER, MOD_BITS'(RESET_MULTIPLIER));
        write_reg(REG_INCREMENT, MOD_BITS'(RESET_INCREMENT));
        write_reg(REG_MODULUS, RESET_MODULUS);
      end
      1: begin
        // power-of-two modulus with a full-period multiplier and odd increment
        m = MOD_BITS'(1) << $urandom_range(2, 7);
        write_reg(REG_MULTIPLIER, MOD_BITS'({$urandom() >> 2, 2'b01}));
        write_reg(REG_INCREMENT, MOD_BITS'($urandom() | 32'd1));
        write_reg(REG_MODULUS, m);
      end
      2: begin
        m = MOD_BITS'($urandom_range(2, 97));
        write_reg(REG_MULTIPLIER, MOD_BITS'($urandom_range(0, 32'(m) - 1)));
        write_reg(REG_INCREMENT, MOD_BITS'($urandom_range(0, 32'(m) - 1)));
        write_reg(REG_MODULUS, m);
      end
      3: begin
        write_reg(REG_MULTIPLIER, MOD_BITS'(32'hFFFF_FFFF));
        write_reg(REG_INCREMENT, MOD_BITS'(32'hFFFF_FFFF));
        write_reg(REG_MODULUS, '1);
      end
      4: begin
        write_reg(REG_MULTIPLIER, MOD_BITS'($urandom()));
        write_reg(REG_INCREMENT, MOD_BITS'($urandom()));
        write_reg(REG_MODULUS, '0);
      end
      5: begin
        write_reg(REG_MULTIPLIER, MOD_BITS'($urandom()));
        write_reg(REG_INCREMENT, MOD_BITS'($urandom()));
        write_reg(REG_MODULUS, {1'($urandom_range(0, 1)), $urandom()});
      end
      6: begin
        write_reg(REG_MULTIPLIER, '0);
        write_reg(REG_INCREMENT, '0);
        write_reg(REG_MODULUS, MOD_BITS'(1));
      end
      default: begin
        // counting sequence: period equals the modulus
        write_reg(REG_MULTIPLIER, MOD_BITS'(1));
        write_reg(REG_INCREMENT, MOD_BITS'(1));
        write_reg(REG_MODULUS, MOD_BITS'($urandom_range(2, 40)));
      end
    endcase
    write_reg(REG_UNUSED, {1'b1, $urandom()});
  endtask

  // Stimulus: directed plan, then seeded runs under several settings
  initial begin : stimulus
    plan_row_t           plan[$];
    int unsigned         base;
    int unsigned         run_len;
    logic [OUT_BITS-1:0] seed;
    bit                  small_mod;

    gen_cfg    = '{multiplier: RESET_MULTIPLIER, increment: RESET_INCREMENT,
                   modulus: RESET_MODULUS};
    gen_value  = RESET_SEED;
    gen_anchor = RESET_SEED;
    gen_steps  = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan.push_back(word_row(OP_STEP, '0));
    plan.push_back(known_row(OP_LOAD, '0, '0, '0, 1'b0));
    plan.push_back(known_row(OP_LOAD, '1, '1, '0, 1'b0));
    plan.push_back(word_row(OP_STEP, 32'h1234_5678));
    // write to an unused index must leave the registers alone
    plan.push_back(reg_row(REG_UNUSED, '1));
    plan.push_back(word_row(OP_STEP, '0));
    // identity map lands on the reference at once
    plan.push_back(reg_row(REG_MULTIPLIER, MOD_BITS'(1)));
    plan.push_back(reg_row(REG_INCREMENT, '0));
    plan.push_back(known_row(OP_LOAD, 32'hA5A5_A5A5, 32'hA5A5_A5A5, '0, 1'b0));
    plan.push_back(known_row(OP_STEP, '0, 32'hA5A5_A5A5, '0, 1'b1));
    // largest product with zero modulus: low word of the sum is zero
    plan.push_back(reg_row(REG_MULTIPLIER, MOD_BITS'(32'hFFFF_FFFF)));
    plan.push_back(reg_row(REG_INCREMENT, MOD_BITS'(32'hFFFF_FFFF)));
    plan.push_back(reg_row(REG_MODULUS, '0));
    plan.push_back(known_row(OP_LOAD, '1, '1, '0, 1'b0));
    plan.push_back(known_row(OP_STEP, '0, '0, CNT_BITS'(1), 1'b0));
    plan.push_back(reg_row(REG_MULTIPLIER, '0));
    plan.push_back(reg_row(REG_INCREMENT, MOD_BITS'(5)));
    plan.push_back(known_row(OP_STEP, '0, OUT_BITS'(5), CNT_BITS'(2), 1'b0));
    plan.push_back(reg_row(REG_MODULUS, MOD_BITS'(1)));
    plan.push_back(known_row(OP_STEP, '0, '0, CNT_BITS'(3), 1'b0));
    // modulus above the state range: remainder is cut to the state width
    plan.push_back(reg_row(REG_MULTIPLIER, MOD_BITS'(1)));
    plan.push_back(reg_row(REG_INCREMENT, MOD_BITS'(32'hFFFF_FFFF)));
    plan.push_back(reg_row(REG_MODULUS, '1));
    plan.push_back(known_row(OP_LOAD, '1, '1, '0, 1'b0));
    plan.push_back(known_row(OP_STEP, '0, 32'hFFFF_FFFE, CNT_BITS'(1), 1'b0));
    // full period of eight: the eighth step returns to the seed
    plan.push_back(reg_row(REG_MULTIPLIER, MOD_BITS'(5)));
    plan.push_back(reg_row(REG_INCREMENT, MOD_BITS'(1)));
    plan.push_back(reg_row(REG_MODULUS, MOD_BITS'(8)));
    plan.push_back(known_row(OP_LOAD, OUT_BITS'(3), OUT_BITS'(3), '0, 1'b0));
    for (int i = 0; i < 8; i++) plan.push_back(word_row(OP_STEP, $urandom()));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].reg_idx, plan[i].wdata);
      else send_word(plan[i].op, plan[i].seed, plan[i].known, plan[i].want);
    end

    for (int unsigned sel = 0; sel < 8; sel++) begin
      apply_setting(sel);
      base = words_sent;
      small_mod = (gen_cfg.modulus != '0) && (gen_cfg.modulus <= MOD_BITS'(256));
      while (words_sent - base < WORDS_PER_SETTING) begin
        if ($urandom_range(7) == 0) begin
          // stray word: any operation, any seed
          send_random(1'($urandom_range(0, 1)), $urandom());
        end else begin
          if (small_mod && $urandom_range(9) != 0)
            seed = $urandom_range(0, 32'(gen_cfg.modulus) - 1);
          else
            seed = $urandom();
          run_len = small_mod ? $urandom_range(1, 2 * 32'(gen_cfg.modulus) + 3)
                              : $urandom_range(1, 12);
          send_random(OP_LOAD, seed);
          repeat (run_len) send_random(OP_STEP, $urandom());
        end
      end
    end

    cfg_we_i <= 1'b0;
    in_valid_i <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Receiver: check each word against the oldest prediction, throttle ready
  initial begin : receiver
    lcg_word_t   want;
    int unsigned hold_left;
    bit          squeezed;
    hold_left = 0;
    squeezed  = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        words_checked++;
        if (words_due.size() == 0) begin
          report_mismatch("word with none due", 64'(value_o), '0);
        end else begin
          want = words_due.pop_front();
          if (value_o !== want.value)
            report_mismatch("value", 64'(value_o), 64'(want.value));
          if (step_count_o !== want.steps)
            report_mismatch("step_count", 64'(step_count_o), 64'(want.steps));
          if (period_complete_o !== want.wrapped)
            report_mismatch("period_complete", 64'(period_complete_o), 64'(want.wrapped));
        end
      end
      // hold off once for long enough that the input side backs up
      if (!squeezed && words_checked >= SQUEEZE_AT) begin
        squeezed  = 1'b1;
        hold_left = SQUEEZE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_gap_pct());
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule

// File: filelist.f
design/lcgpd_pkg.sv
design/lcgpd_mulmod.sv
design/lcg_with_period_detect_core.sv
dv/lcg_with_period_detect_core_tb.sv
